// File: rtl/rotary_encoder_step_decoder_core_defines.svh
// ----------------------------------------------------------------------------
// Rotary encoder step decoder: assertion macros
// Shared concurrent assertion forms for the checker of the decoder core.
// ----------------------------------------------------------------------------
`ifndef ROTARY_ENCODER_STEP_DECODER_CORE_DEFINES_SVH
`define ROTARY_ENCODER_STEP_DECODER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define RENC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define RENC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/rotenc_pkg.sv
// ----------------------------------------------------------------------------
// Rotary encoder step decoder package
// Field widths, reset values, step codes and the decode result struct.
// ----------------------------------------------------------------------------
package rotenc_pkg;

  localparam int unsigned LevelsW   = 2;
  localparam int unsigned TimeW     = 32;
  localparam int unsigned DebounceW = 8;
  localparam int unsigned StepW     = 2;

  // Bit positions of the two lines inside a level sample
  localparam int unsigned LineABit = 0;
  localparam int unsigned LineBBit = 1;

  localparam logic [LevelsW-1:0]   LevelsReset   = 2'b11;
  localparam logic [DebounceW-1:0] DebounceReset = 8'd5;

  typedef enum logic [StepW-1:0] {
    STEP_NONE = 2'd0,
    STEP_UP   = 2'd1,
    STEP_DOWN = 2'd2
  } step_t;

  // Result of decoding one sample against the tracked state
  typedef struct packed {
    step_t step;        // emitted step after debounce
    logic  locked_nxt;  // phase lock after this sample
    logic  stamp;       // load the sample time as last step time
  } dec_t;

endpackage

// File: rtl/rotenc_decode.sv
// ----------------------------------------------------------------------------
// Rotary encoder sample decode
// Edge detection, phase lock and debounce check for one line sample.
// ----------------------------------------------------------------------------
module rotenc_decode
  import rotenc_pkg::*;
(
  input  logic [LevelsW-1:0]   levels,
  input  logic [LevelsW-1:0]   prev_levels,
  input  logic                 locked,
  input  logic [TimeW-1:0]     now_ms,
  input  logic [TimeW-1:0]     last_step_time,
  input  logic [DebounceW-1:0] debounce_ms,
  output dec_t                 dec
);

  logic             a_low;
  logic             b_low;
  logic             a_diff;
  logic             b_diff;
  logic             lock_held;
  step_t            raw_step;
  logic             arm;
  logic [TimeW-1:0] elapsed;
  logic             too_soon;

  assign a_low  = ~levels[LineABit];
  assign b_low  = ~levels[LineBBit];
  assign a_diff = levels[LineABit] ^ prev_levels[LineABit];
  assign b_diff = levels[LineBBit] ^ prev_levels[LineBBit];

  // Release the lock when both lines are back high
  assign lock_held = locked & (a_low | b_low);

  // Falling edges first (they arm the lock), then rising edges while unlocked
  always_comb begin
    raw_step = STEP_NONE;
    arm      = 1'b0;
    if (!lock_held && a_diff && a_low && !b_low) begin
      raw_step = STEP_UP;
      arm      = 1'b1;
    end else if (!lock_held && b_diff && b_low && !a_low) begin
      raw_step = STEP_DOWN;
      arm      = 1'b1;
    end else if (!lock_held && a_diff && !a_low && b_low) begin
      raw_step = STEP_UP;
    end else if (!lock_held && b_diff && !b_low && a_low) begin
      raw_step = STEP_DOWN;
    end
  end

  // Debounce against the last emitted step, modulo 2^32
  assign elapsed  = now_ms - last_step_time;
  assign too_soon = elapsed < {{(TimeW-DebounceW){1'b0}}, debounce_ms};

  always_comb begin
    dec.locked_nxt = lock_held | arm;
    dec.stamp      = 1'b0;
    dec.step       = STEP_NONE;
    if (raw_step != STEP_NONE && !too_soon) begin
      dec.step  = raw_step;
      dec.stamp = 1'b1;
    end
  end

endmodule

// File: rtl/rotary_encoder_step_decoder_core.sv
// ----------------------------------------------------------------------------
// Rotary encoder step decoder core
// Turns timestamped quadrature line samples into debounced up/down steps.
// ----------------------------------------------------------------------------
// Each accepted transaction carries one sample of lines A and B (bit0 A,
// bit1 B, 1 = high) with a millisecond timestamp, and yields exactly one
// result transaction: 0 no step, 1 up, 2 down. A transaction passes an input
// register, combinational decode and a result register; while the result
// register is free or draining a new sample is taken every cycle, one
// transaction per cycle, with line history, phase lock and last step time
// updated once per sample. A stalled result holds in the output register
// while the input register still fills. The user writes debounce_ms (reset 5)
// through cfg_wr_en/cfg_wr_data only while idle; the block does not enforce it.
module rotary_encoder_step_decoder_core
  import rotenc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [LevelsW-1:0]   in_line_levels,
  input  logic [TimeW-1:0]     in_now_ms,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [StepW-1:0]     out_step,
  input  logic                 cfg_wr_en,
  input  logic [DebounceW-1:0] cfg_wr_data
);

  logic                 in_v_r;
  logic [LevelsW-1:0]   in_levels_r;
  logic [TimeW-1:0]     in_now_r;
  logic                 out_v_r;
  step_t                out_step_r;
  logic [DebounceW-1:0] debounce_r;
  logic [LevelsW-1:0]   prev_levels_r;
  logic                 locked_r;
  logic [TimeW-1:0]     last_time_r;
  logic                 advance;
  logic                 take;
  dec_t                 dec;

  // Move the held sample on when the result register is free or draining
  assign advance  = !out_v_r || out_ready;
  assign take     = in_v_r && advance;
  assign in_ready = !in_v_r || advance;

  // Hold the debounce setting
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= DebounceReset;
    end else if (cfg_wr_en) begin
      debounce_r <= cfg_wr_data;
    end
  end

  // Capture the input transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_levels_r <= in_line_levels;
      in_now_r    <= in_now_ms;
    end
  end

  rotenc_decode u_decode (
    .levels         (in_levels_r),
    .prev_levels    (prev_levels_r),
    .locked         (locked_r),
    .now_ms         (in_now_r),
    .last_step_time (last_time_r),
    .debounce_ms    (debounce_r),
    .dec            (dec)
  );

  // Advance the line history, lock and last step time once per sample
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_levels_r <= LevelsReset;
      locked_r      <= 1'b0;
      last_time_r   <= '0;
    end else if (take) begin
      prev_levels_r <= in_levels_r;
      locked_r      <= dec.locked_nxt;
      if (dec.stamp) begin
        last_time_r <= in_now_r;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= in_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_step_r <= dec.step;
    end
  end

  assign out_valid = out_v_r;
  assign out_step  = out_step_r;

endmodule

// File: rtl/rotenc_checker.sv
// ----------------------------------------------------------------------------
// Rotary encoder step decoder checker
// Port-level assertions on the decoder core, attached by bind.
// ----------------------------------------------------------------------------
`include "rotary_encoder_step_decoder_core_defines.svh"

module rotenc_checker
  import rotenc_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [StepW-1:0] out_step
);

  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // Track transactions accepted but not yet delivered
  always_comb begin
    cnt_nxt = cnt_r;
    if (in_acc && !out_acc) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!in_acc && out_acc) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  `RENC_ASSERT_IMPL(a_step_code, clk, rst_n, out_valid, out_step != 2'd3, "invalid step code")
  `RENC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
                    out_valid && $stable(out_step), "stalled result changed")
  `RENC_ASSERT_IMPL(a_no_invent, clk, rst_n, out_valid, cnt_r != 2'd0, "result without transaction")
  `RENC_ASSERT_IMPL(a_depth, clk, rst_n, 1'b1, cnt_r != 2'd3, "more than two in flight")
  `RENC_ASSERT_IMPL(a_accept_free, clk, rst_n, !out_valid, in_ready, "input blocked while empty")

endmodule

bind rotary_encoder_step_decoder_core rotenc_checker u_rotenc_checker (.*);

// File: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Rotary encoder step decoder core testbench
// Sends timestamped line samples, mostly clean detent sequences with random
// timing plus glitches and broken sequences, through the valid/ready ports.
// A local decoder predicts the step of every sample, and each result
// transaction is checked against the oldest prediction. Traffic runs with
// random idling on both sides under several debounce settings.
// ----------------------------------------------------------------------------
module tb;
  import rotenc_pkg::*;

  localparam int unsigned StallLimit    = 3000;
  localparam int unsigned HoldoffCycles = 200;
  localparam int unsigned DrainCycles   = 4;

  typedef struct {
    logic [LevelsW-1:0] levels;
    logic [TimeW-1:0]   stamp;
  } line_sample_t;

  logic                 clk            = 1'b0;
  logic                 rst_n          = 1'b0;
  logic                 in_valid       = 1'b0;
  logic                 in_ready;
  logic [LevelsW-1:0]   in_line_levels = LevelsReset;
  logic [TimeW-1:0]     in_now_ms      = '0;
  logic                 out_valid;
  logic                 out_ready      = 1'b0;
  logic [StepW-1:0]     out_step;
  logic                 cfg_wr_en      = 1'b0;
  logic [DebounceW-1:0] cfg_wr_data    = '0;

  // Samples waiting to be sent, and steps waiting to come back
  line_sample_t pending_samples[$];
  step_t        expected_steps[$];

  // Decoder state mirrored from the block
  logic [LevelsW-1:0]   enc_prev_levels = LevelsReset;
  logic                 enc_locked      = 1'b0;
  logic [TimeW-1:0]     enc_last_stamp  = '0;
  logic [DebounceW-1:0] enc_debounce    = DebounceReset;

  int unsigned samples_queued   = 0;
  int unsigned samples_accepted = 0;
  int unsigned steps_checked    = 0;
  int unsigned ups_seen         = 0;
  int unsigned downs_seen       = 0;
  int unsigned settings_used    = 1;
  int unsigned fail_count       = 0;
  int unsigned sender_idle_pct  = 0;
  int unsigned recv_idle_pct    = 0;
  int unsigned holdoff_req      = 0;
  int unsigned holdoff_taken    = 0;
  int unsigned holdoff_left     = 0;
  int unsigned stall_cycles     = 0;
  logic [TimeW-1:0] stim_ms     = '0;

  rotary_encoder_step_decoder_core uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_line_levels (in_line_levels),
    .in_now_ms      (in_now_ms),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_step       (out_step),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Decode one sample against the mirrored state and advance that state
  function automatic step_t decode_step(input logic [LevelsW-1:0] levels,
                                        input logic [TimeW-1:0] stamp);
    logic [LevelsW-1:0] changed;
    logic               a_high, b_high, a_chg, b_chg;
    logic [TimeW-1:0]   elapsed;
    step_t              dir;
    changed = enc_prev_levels ^ levels;
    a_high  = levels[LineABit];
    b_high  = levels[LineBBit];
    a_chg   = changed[LineABit];
    b_chg   = changed[LineBBit];
    dir     = STEP_NONE;
    // Release the lock when both lines are back high
    if (a_high && b_high) begin
      enc_locked = 1'b0;
    end
    // Falling edges arm the lock, A before B
    if (!enc_locked && a_chg && !a_high && b_high) begin
      dir        = STEP_UP;
      enc_locked = 1'b1;
    end else if (!enc_locked && b_chg && !b_high && a_high) begin
      dir        = STEP_DOWN;
      enc_locked = 1'b1;
    end
    // Rising edges count only while unlocked
    if (dir == STEP_NONE && !enc_locked && a_chg && a_high && !b_high) begin
      dir = STEP_UP;
    end
    if (dir == STEP_NONE && !enc_locked && b_chg && b_high && !a_high) begin
      dir = STEP_DOWN;
    end
    // Drop steps inside the debounce window, wrapping time
    if (dir != STEP_NONE) begin
      elapsed = stamp - enc_last_stamp;
      if (elapsed < TimeW'(enc_debounce)) begin
        dir = STEP_NONE;
      end else begin
        enc_last_stamp = stamp;
      end
    end
    enc_prev_levels = levels;
    return dir;
  endfunction

  // Driver: record accepted transactions, then offer the next sample
  always @(posedge clk) begin
    line_sample_t item;
    step_t        want;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        want = decode_step(in_line_levels, in_now_ms);
        expected_steps.push_back(want);
        samples_accepted++;
        if (want == STEP_UP) ups_seen++;
        if (want == STEP_DOWN) downs_seen++;
      end
      if (!in_valid || in_ready) begin
        if (pending_samples.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
          item = pending_samples.pop_front();
          in_line_levels <= item.levels;
          in_now_ms      <= item.stamp;
          in_valid       <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result transaction and pace out_ready
  always @(posedge clk) begin
    step_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        steps_checked++;
        if (expected_steps.size() == 0) begin
          $error("step: unexpected result %0d with no sample outstanding", out_step);
          fail_count++;
        end else begin
          want = expected_steps.pop_front();
          if (out_step !== want) begin
            $error("step mismatch: expected %0d, actual %0d", want, out_step);
            fail_count++;
          end
        end
      end
      // Hold off for a long stretch when asked
      if (holdoff_req != holdoff_taken) begin
        holdoff_taken = holdoff_req;
        holdoff_left  = HoldoffCycles;
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= StallLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic push_sample(input logic [LevelsW-1:0] levels,
                             input logic [TimeW-1:0] stamp);
    line_sample_t item;
    item.levels = levels;
    item.stamp  = stamp;
    pending_samples.push_back(item);
    samples_queued++;
  endtask

  // Advance the stimulus clock, with rare jumps and step backs
  task automatic push_timed(input logic [LevelsW-1:0] levels);
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 2) begin
      stim_ms = $urandom;
    end else if (pick < 3) begin
      stim_ms = 32'hFFFF_FFFF - $urandom_range(0, 600);
    end else if (pick < 5) begin
      stim_ms = stim_ms - $urandom_range(0, 20);
    end else begin
      stim_ms = stim_ms + $urandom_range(0, enc_debounce / 2 + 2);
    end
    push_sample(levels, stim_ms);
  endtask

  // Mix clean detents, broken sequences and line noise
  task automatic push_random_samples(input int unsigned count);
    logic [LevelsW-1:0] cw[4]  = '{2'b10, 2'b00, 2'b01, 2'b11};
    logic [LevelsW-1:0] ccw[4] = '{2'b01, 2'b00, 2'b10, 2'b11};
    int unsigned        added, pick, cut, k;
    logic               up;
    added = 0;
    while (added < count) begin
      pick = $urandom_range(99);
      up   = 1'($urandom_range(1));
      if (pick < 70) begin
        for (k = 0; k < 4; k++) begin
          push_timed(up ? cw[k] : ccw[k]);
        end
        added += 4;
      end else if (pick < 82) begin
        // Stop partway and turn back
        cut = $urandom_range(1, 3);
        for (k = 0; k < cut; k++) begin
          push_timed(up ? cw[k] : ccw[k]);
        end
        for (k = cut; k > 0; k--) begin
          push_timed(up ? cw[k-1] : ccw[k-1]);
        end
        push_timed(2'b11);
        added += 2 * cut + 1;
      end else if (pick < 90) begin
        // Contact bounce on the leading edge
        for (k = 0; k < 3; k++) begin
          push_timed(up ? cw[0] : ccw[0]);
          push_timed(2'b11);
        end
        added += 6;
      end else begin
        cut = $urandom_range(1, 4);
        for (k = 0; k < cut; k++) begin
          push_timed(LevelsW'($urandom_range(3)));
        end
        added += cut;
      end
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (samples_accepted != samples_queued || expected_steps.size() != 0);
  endtask

  task automatic write_debounce(input logic [DebounceW-1:0] value);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    enc_debounce = value;
    settings_used++;
  endtask

  task automatic set_idling(input int unsigned sender_pct, input int unsigned recv_pct);
    @(negedge clk);
    sender_idle_pct = sender_pct;
    recv_idle_pct   = recv_pct;
  endtask

  // Test sequence
  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    set_idling(28, 77);

    // Directed samples under the reset debounce
    push_sample(2'b10, 32'd3);          // step right after reset, too early
    push_sample(2'b11, 32'd4);
    push_sample(2'b10, 32'd10);         // clean up step
    push_sample(2'b00, 32'd11);
    push_sample(2'b01, 32'd12);
    push_sample(2'b11, 32'd13);
    push_sample(2'b01, 32'd14);         // down inside the window
    push_sample(2'b11, 32'd20);
    push_sample(2'b01, 32'd20);         // down, after the lock armed by the dropped step is released
    push_sample(2'b11, 32'd21);
    push_sample(2'b00, 32'd30);         // both lines fall at once
    push_sample(2'b01, 32'd31);         // rising A with B low
    push_sample(2'b10, 32'd40);         // both change, A falls first
    push_sample(2'b01, 32'd50);         // both change while locked
    push_sample(2'b11, 32'd51);
    push_sample(2'b00, 32'd52);
    push_sample(2'b10, 32'd60);         // rising B with A low
    push_sample(2'b11, 32'hFFFF_FFF0);
    push_sample(2'b10, 32'hFFFF_FFFF);
    push_sample(2'b11, 32'd0);
    push_sample(2'b01, 32'd3);          // window across the time wrap
    push_sample(2'b11, 32'd4);
    push_sample(2'b01, 32'd4);
    push_sample(2'b11, 32'h8000_0000);
    stim_ms = 32'h8000_0000;
    wait_drained();

    // Zero and full debounce
    write_debounce(8'd0);
    push_random_samples(200);
    wait_drained();
    write_debounce(8'd255);
    push_random_samples(150);
    wait_drained();

    // Swap the idling of the two sides
    set_idling(77, 28);
    write_debounce(DebounceW'($urandom_range(2, 254)));
    push_random_samples(150);
    wait_drained();
    push_random_samples(150);
    wait_drained();

    // Full rate, with a long receiver stall while samples keep coming
    set_idling(0, 0);
    write_debounce(8'd1);
    push_random_samples(300);
    holdoff_req++;
    wait_drained();
    write_debounce(DebounceW'($urandom_range(0, 255)));
    push_random_samples(180);
    wait_drained();
    repeat (DrainCycles) @(posedge clk);

    $display("Checked %0d samples over %0d debounce settings: %0d up, %0d down steps.",
             steps_checked, settings_used, ups_seen, downs_seen);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
